FILE: hw/rtl/tpre_pkg.sv
// Shared types and constants for the photon record encoder.
// No dependencies; every other file of the block but tpre_if imports this package.
package tpre_pkg;

   localparam int MAP_ENTRIES = 8;
   localparam int MACRO_LIMIT = 4095;
   localparam int MT_BITS     = 12;
   localparam int N_BITS      = 28;
   localparam int OV_BITS     = 52;
   localparam int T_BITS      = 65;
   localparam int C_BITS      = 66;
   localparam int CNT_BITS    = 7;

   localparam logic [CNT_BITS-1:0] DIV1_LAST = CNT_BITS'(T_BITS - 1);
   localparam logic [CNT_BITS-1:0] DIV2_LAST = CNT_BITS'(31);
   localparam logic [N_BITS-1:0]   N_MAX     = {N_BITS{1'b1}};
   localparam logic [3:0]          OVF_TAG   = 4'hC;

   localparam logic [2:0] REG_SYNC_PERIOD   = 3'd0;
   localparam logic [2:0] REG_MICRO_RES     = 3'd1;
   localparam logic [2:0] REG_MACRO_TICK    = 3'd2;
   localparam logic [2:0] REG_N_MICRO       = 3'd3;
   localparam logic [2:0] REG_REVERSE       = 3'd4;
   localparam logic [2:0] REG_CHANNEL_MAP   = 3'd5;
   localparam logic [2:0] REG_MAP_ENTRIES   = 3'd6;

   typedef struct packed {
      logic [31:0] sync_period;
      logic [23:0] micro_resolution;
      logic [15:0] macro_tick;
      logic [15:0] n_micro_channels;
      logic        reverse_micro;
      logic [31:0] channel_map;
      logic [3:0]  channel_map_entries;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        macro_count;
      logic [31:0]        sub_time;
      logic signed [15:0] detector;
      logic [15:0]        micro_channel;
      logic               has_micro;
   } photon_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic load1;
      logic div_step;
      logic ceil;
      logic diff;
      logic split;
      logic load2;
      logic tac;
      logic load_ovf;
      logic load_pho;
   } cmd_type;

   typedef struct packed {
      logic need_ovf;
      logic out_free;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_DIV1, ST_CEIL, ST_DIFF, ST_SPLIT,
      ST_DIV2, ST_TAC, ST_EMIT_OVF, ST_EMIT_PHO
   } state_type;

endpackage

FILE: hw/rtl/tpre_if.sv
// Handshake channel interfaces for photon requests and record responses.
// Depends on nothing; field widths follow the block's item definitions.
interface tpre_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        macro_count;
   logic [31:0]        sub_time;
   logic signed [15:0] detector;
   logic [15:0]        micro_channel;
   logic               has_micro;
   modport source (output valid, macro_count, sub_time, detector, micro_channel, has_micro,
                   input ready);
   modport sink (input valid, macro_count, sub_time, detector, micro_channel, has_micro,
                 output ready);
endinterface

interface tpre_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] record_word;
   logic        is_overflow;
   logic        last;
   modport source (output valid, record_word, is_overflow, last, input ready);
   modport sink (input valid, record_word, is_overflow, last, output ready);
endinterface

FILE: hw/rtl/tpre_csr.sv
// APB-style configuration register file of the photon record encoder.
// Depends on tpre_pkg for the register indexes and the cfg_type struct.
module tpre_csr
   import tpre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx    = paddr[4:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_SYNC_PERIOD: cfg_in.sync_period         = pwdata;
            REG_MICRO_RES:   cfg_in.micro_resolution    = pwdata[23:0];
            REG_MACRO_TICK:  cfg_in.macro_tick          = pwdata[15:0];
            REG_N_MICRO:     cfg_in.n_micro_channels    = pwdata[15:0];
            REG_REVERSE:     cfg_in.reverse_micro       = pwdata[0];
            REG_CHANNEL_MAP: cfg_in.channel_map         = pwdata;
            REG_MAP_ENTRIES: cfg_in.channel_map_entries = pwdata[3:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SYNC_PERIOD: prdata = cfg_ff.sync_period;
         REG_MICRO_RES:   prdata = {8'd0, cfg_ff.micro_resolution};
         REG_MACRO_TICK:  prdata = {16'd0, cfg_ff.macro_tick};
         REG_N_MICRO:     prdata = {16'd0, cfg_ff.n_micro_channels};
         REG_REVERSE:     prdata = {31'd0, cfg_ff.reverse_micro};
         REG_CHANNEL_MAP: prdata = cfg_ff.channel_map;
         REG_MAP_ENTRIES: prdata = {28'd0, cfg_ff.channel_map_entries};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_period         <= 32'd12500;
         cfg_ff.micro_resolution    <= 24'd3;
         cfg_ff.macro_tick          <= 16'd1;
         cfg_ff.n_micro_channels    <= 16'd4096;
         cfg_ff.reverse_micro       <= 1'b0;
         cfg_ff.channel_map         <= 32'd0;
         cfg_ff.channel_map_entries <= 4'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/tpre_ctrl.sv
// Sequencer of the photon record encoder: walks one photon through the datapath.
// Depends on tpre_pkg for the state, command and status types.
module tpre_ctrl
   import tpre_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.load1 = 1'b1;
            cnt_in    = DIV1_LAST;
            state_in  = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) state_in = ST_CEIL;
         end
         ST_CEIL: begin
            cmd.ceil = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            cmd.load2 = 1'b1;
            cnt_in    = DIV2_LAST;
            state_in  = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) state_in = ST_TAC;
         end
         ST_TAC: begin
            cmd.tac  = 1'b1;
            state_in = status.need_ovf ? ST_EMIT_OVF : ST_EMIT_PHO;
         end
         ST_EMIT_OVF: begin
            if (status.out_free) begin
               cmd.load_ovf = 1'b1;
               state_in     = ST_EMIT_PHO;
            end
         end
         ST_EMIT_PHO: begin
            if (status.out_free) begin
               cmd.load_pho = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/tpre_dp.sv
// Datapath: wrap extension, absolute time, shared serial divider, record assembly.
// Depends on tpre_pkg; driven by commands from tpre_ctrl.
module tpre_dp
   import tpre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  photon_type  item,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        out_ready,
   output logic        out_valid,
   output logic [31:0] out_record_word,
   output logic        out_is_overflow,
   output logic        out_last
);

   photon_type          item_ff;
   logic [15:0]         wrap_ff, wrap_in;
   logic [31:0]         prev_ff;
   logic                seen_ff;
   logic [OV_BITS-1:0]  ov_ff, ov_in;
   logic [47:0]         prod_a_ff;
   logic [31:0]         prod_b_ff;
   logic [T_BITS-1:0]   divq_ff, divq_in;
   logic [31:0]         divr_ff, divr_in;
   logic [31:0]         divd_ff, divd_in;
   logic [C_BITS-1:0]   c_ff, d_ff;
   logic                neg_ff;
   logic [31:0]         ph_ff;
   logic [N_BITS-1:0]   n_ff, n_in;
   logic [MT_BITS-1:0]  mt_ff, mt_in;
   logic                ovf_ff, ovf_in;
   logic [15:0]         tac_ff, tac_in;
   logic                valid_ff, valid_in;
   logic [31:0]         word_ff, word_in;
   logic                isovf_ff, isovf_in;
   logic                last_ff, last_in;

   logic [31:0]         per;
   logic [23:0]         res;
   logic [T_BITS-1:0]   t_sum;
   logic [32:0]         rs;
   logic                ge;
   logic [32:0]         rsub;
   logic [C_BITS-1:0]   k_ext;
   logic [OV_BITS:0]    ov_sum;
   logic [17:0]         rev_micro;
   logic [32:0]         val;
   logic [3:0]          entries;
   logic                map_hit;
   logic [3:0]          nibble;

   assign per = (cfg.sync_period == '0) ? 32'd1 : cfg.sync_period;
   assign res = (cfg.micro_resolution == '0) ? 24'd1 : cfg.micro_resolution;

   // Count a wrap when the macro count falls back by more than half its range.
   always_comb begin
      wrap_in = wrap_ff;
      if (seen_ff && item.macro_count < prev_ff &&
          (prev_ff - item.macro_count) > 32'h8000_0000)
         wrap_in = wrap_ff + 16'd1;
   end

   assign t_sum = {1'b0, prod_b_ff, 32'd0} + {17'd0, prod_a_ff} + {33'd0, item_ff.sub_time};

   // One restoring division step.
   assign rs   = {divr_ff, divq_ff[T_BITS-1]};
   assign ge   = rs >= {1'b0, divd_ff};
   assign rsub = rs - {1'b0, divd_ff};

   always_comb begin
      divq_in = divq_ff;
      divr_in = divr_ff;
      divd_in = divd_ff;
      if (cmd.load1) begin
         divq_in = t_sum;
         divr_in = '0;
         divd_in = per;
      end else if (cmd.load2) begin
         divq_in = {ph_ff, 33'd0};
         divr_in = '0;
         divd_in = {8'd0, res};
      end else if (cmd.div_step) begin
         divq_in = {divq_ff[T_BITS-2:0], ge};
         divr_in = ge ? rsub[31:0] : rs[31:0];
      end
   end

   assign k_ext = {2'd0, ov_ff, 12'd0};

   // Split the macrotime distance into overflow count and residue.
   always_comb begin
      n_in   = '0;
      mt_in  = d_ff[MT_BITS-1:0];
      ovf_in = 1'b0;
      if (neg_ff) begin
         mt_in = '0;
      end else if (d_ff[C_BITS-1:64] != '0) begin
         n_in   = N_MAX;
         mt_in  = MT_BITS'(MACRO_LIMIT);
         ovf_in = 1'b1;
      end else if (d_ff[63:MT_BITS] != '0) begin
         ovf_in = 1'b1;
         if (d_ff[63:MT_BITS+N_BITS] != '0) begin
            n_in  = N_MAX;
            mt_in = MT_BITS'(MACRO_LIMIT);
         end else begin
            n_in = d_ff[MT_BITS+N_BITS-1:MT_BITS];
         end
      end
   end

   assign ov_sum = {1'b0, ov_ff} + {{(OV_BITS+1-N_BITS){1'b0}}, n_ff};
   assign ov_in  = ov_sum[OV_BITS] ? {OV_BITS{1'b1}} : ov_sum[OV_BITS-1:0];

   // Micro channel: input (reversed if configured), or phase quotient, then clamp.
   assign rev_micro = {2'd0, cfg.n_micro_channels} - {2'd0, item_ff.micro_channel} - 18'd1;

   always_comb begin
      if (item_ff.has_micro)
         val = cfg.reverse_micro ? {{15{rev_micro[17]}}, rev_micro}
                                 : {17'd0, item_ff.micro_channel};
      else
         val = {1'b0, divq_ff[31:0]};
      if (cfg.n_micro_channels == '0 || val[32])
         tac_in = '0;
      else if (val[31:0] >= {16'd0, cfg.n_micro_channels})
         tac_in = cfg.n_micro_channels - 16'd1;
      else
         tac_in = val[15:0];
   end

   assign entries = (cfg.channel_map_entries > 4'(MAP_ENTRIES)) ? 4'(MAP_ENTRIES)
                                                                : cfg.channel_map_entries;
   assign map_hit = !item_ff.detector[15] &&
                    ({1'b0, item_ff.detector[14:0]} < {12'd0, entries});
   assign nibble  = map_hit ? cfg.channel_map[{item_ff.detector[2:0], 2'b00} +: 4]
                            : item_ff.detector[3:0];

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      isovf_in = isovf_ff;
      last_in  = last_ff;
      if (valid_ff && out_ready) valid_in = 1'b0;
      if (cmd.load_ovf) begin
         valid_in = 1'b1;
         word_in  = {OVF_TAG, n_ff};
         isovf_in = 1'b1;
         last_in  = 1'b0;
      end else if (cmd.load_pho) begin
         valid_in = 1'b1;
         word_in  = {tac_ff, nibble, mt_ff};
         isovf_in = 1'b0;
         last_in  = 1'b1;
      end
   end

   assign status.need_ovf = ovf_ff;
   assign status.out_free = !valid_ff || out_ready;

   assign out_valid       = valid_ff;
   assign out_record_word = word_ff;
   assign out_is_overflow = isovf_ff;
   assign out_last        = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff  <= '0;
         prev_ff  <= '0;
         seen_ff  <= 1'b0;
         ov_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.capture) begin
            wrap_ff <= wrap_in;
            prev_ff <= item.macro_count;
            seen_ff <= 1'b1;
         end
         if (cmd.load_ovf) ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= item;
      if (cmd.mul) begin
         prod_a_ff <= cfg.macro_tick * item_ff.macro_count;
         prod_b_ff <= wrap_ff * cfg.macro_tick;
      end
      divq_ff <= divq_in;
      divr_ff <= divr_in;
      divd_ff <= divd_in;
      if (cmd.ceil) begin
         c_ff  <= {1'b0, divq_ff} + {65'd0, (divr_ff != '0)};
         ph_ff <= cfg.reverse_micro ? (divd_ff - divr_ff) : divr_ff;
      end
      if (cmd.diff) begin
         neg_ff <= c_ff < k_ext;
         d_ff   <= c_ff - k_ext;
      end
      if (cmd.split) begin
         n_ff   <= n_in;
         mt_ff  <= mt_in;
         ovf_ff <= ovf_in;
      end
      if (cmd.tac) tac_ff <= tac_in;
      word_ff  <= word_in;
      isovf_ff <= isovf_in;
      last_ff  <= last_in;
   end

endmodule

FILE: hw/rtl/tcspc_photon_record_encoder_core.sv
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    macro_count, sub_time, detector, micro_channel, has_micro
// rsp       out  valid/ready    record_word, is_overflow, last
// csr       in   APB write/read sync_period .. channel_map_entries
//
// From acceptance to its photon record being loaded (after an overflow record when
// one is needed), a photon runs a 65-step division of the absolute time by the sync
// period and a 32-step division of the phase by the micro resolution on one shared
// serial divider; the next photon is taken only after its photon record is loaded.
// Synchronous active-high reset clears the wrap, overflow and sequencer state.
// A new photon is accepted while the last record still waits in the output register;
// rsp stalls only hold the sequencer in its emit states.
// Top level; depends on tpre_pkg, tpre_if, tpre_csr, tpre_ctrl and tpre_dp.
module tcspc_photon_record_encoder_core
   import tpre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tpre_req_if.sink    req,
   tpre_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   photon_type item;
   logic       in_ready;

   assign item.macro_count   = req.macro_count;
   assign item.sub_time      = req.sub_time;
   assign item.detector      = req.detector;
   assign item.micro_channel = req.micro_channel;
   assign item.has_micro     = req.has_micro;
   assign req.ready          = in_ready;

   tpre_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tpre_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   tpre_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .item            (item),
      .cmd             (cmd),
      .status          (status),
      .out_ready       (rsp.ready),
      .out_valid       (rsp.valid),
      .out_record_word (rsp.record_word),
      .out_is_overflow (rsp.is_overflow),
      .out_last        (rsp.last)
   );

   a_ovf_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_overflow |-> !rsp.last && rsp.record_word[31:28] == OVF_TAG)
      else $error("overflow record malformed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("second photon accepted while busy");

   a_tac_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.is_overflow && cfg.n_micro_channels != '0
      |-> rsp.record_word[31:16] < cfg.n_micro_channels)
      else $error("micro channel beyond clamp");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for tcspc_photon_record_encoder_core: drives photons, writes registers over APB,
// and checks every record against an in-bench predictor. Depends on tpre_pkg, tpre_if and the core.
module tb;
   import tpre_pkg::*;

   typedef struct {
      logic [31:0] word;
      logic        ovf;
      logic        last;
   } record_type;

   typedef struct {
      photon_type  p;
      bit          typed;
      logic [31:0] word;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite, pready;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;

   tpre_req_if req_ch();
   tpre_rsp_if rsp_ch();

   tcspc_photon_record_encoder_core uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor copy of configuration and state
   logic [31:0] m_sync, m_map;
   logic [23:0] m_res;
   logic [15:0] m_tick, m_nch, m_wraps;
   logic        m_rev, m_seen;
   logic [3:0]  m_entries;
   logic [31:0] m_prev_macro;
   logic [51:0] m_ovf_total;

   record_type  pending_records[$];
   int          errors = 0;
   bit          calm = 0;
   bit          hold_req = 0;
   logic [31:0] cur_macro = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void predict_records(photon_type p);
      logic [65:0] t, q, k, d, n;
      logic [31:0] per, rem, ph;
      logic [23:0] res;
      longint      tac, nch, dnum, entries;
      logic [11:0] mt;
      logic [5:0]  code;
      record_type  r;
      if (m_seen && p.macro_count < m_prev_macro &&
          (m_prev_macro - p.macro_count) > 32'h8000_0000) m_wraps = m_wraps + 16'd1;
      m_prev_macro = p.macro_count;
      m_seen = 1;
      per = (m_sync == 0) ? 32'd1 : m_sync;
      res = (m_res == 0) ? 24'd1 : m_res;
      t = ((66'(m_wraps) * 66'(m_tick)) << 32) + 66'(m_tick) * 66'(p.macro_count)
          + 66'(p.sub_time);
      q = t / 66'(per);
      rem = 32'(t % 66'(per));
      if (rem != 0) q = q + 66'd1;
      k = 66'(m_ovf_total) << 12;
      if (q < k) begin
         mt = '0;
      end else begin
         d = q - k;
         if (d > 66'(MACRO_LIMIT)) begin
            n = d >> 12;
            if (n > 66'(N_MAX)) n = 66'(N_MAX);
            d = d - (n << 12);
            mt = (d > 66'(MACRO_LIMIT)) ? 12'(MACRO_LIMIT) : d[11:0];
            r.word = {OVF_TAG, n[27:0]};
            r.ovf = 1;
            r.last = 0;
            pending_records = {pending_records, r};
            if ({14'b0, {52{1'b1}}} - 66'(m_ovf_total) < n) m_ovf_total = {52{1'b1}};
            else m_ovf_total = m_ovf_total + n[51:0];
         end else begin
            mt = d[11:0];
         end
      end
      nch = longint'(m_nch);
      if (p.has_micro) begin
         tac = longint'(p.micro_channel);
         if (m_rev) tac = nch - tac - 1;
      end else begin
         ph = m_rev ? per - rem : rem;
         tac = longint'(ph / 32'(res));
      end
      if (nch == 0 || tac < 0) tac = 0;
      else if (tac >= nch) tac = nch - 1;
      dnum = longint'(p.detector);
      entries = (m_entries > MAP_ENTRIES) ? MAP_ENTRIES : longint'(m_entries);
      if (dnum >= 0 && dnum < entries) code = 6'(m_map >> (4 * dnum)) & 6'h0f;
      else code = p.detector[5:0];
      r.word = {tac[15:0], 8'({code, 4'b0} + {6'b0, mt[11:8]}), mt[7:0]};
      r.ovf = 0;
      r.last = 1;
      pending_records = {pending_records, r};
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_SYNC_PERIOD: m_sync = val;
         REG_MICRO_RES:   m_res = val[23:0];
         REG_MACRO_TICK:  m_tick = val[15:0];
         REG_N_MICRO:     m_nch = val[15:0];
         REG_REVERSE:     m_rev = val[0];
         REG_CHANNEL_MAP: m_map = val;
         REG_MAP_ENTRIES: m_entries = val[3:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_records.size() != 0) @(posedge clock);
      // the photon in flight, if any, has already produced its record
      repeat (20) @(posedge clock);
   endtask

   task automatic apply_setting(logic [31:0] sp, logic [31:0] res, logic [31:0] tick,
                                logic [31:0] nch, logic [31:0] rev, logic [31:0] map,
                                logic [31:0] ent);
      drain();
      write_reg(REG_SYNC_PERIOD, sp);
      write_reg(REG_MICRO_RES, res);
      write_reg(REG_MACRO_TICK, tick);
      write_reg(REG_N_MICRO, nch);
      write_reg(REG_REVERSE, rev);
      write_reg(REG_CHANNEL_MAP, map);
      write_reg(REG_MAP_ENTRIES, ent);
   endtask

   task automatic send_photon(photon_type p);
      req_ch.valid <= 1;
      req_ch.macro_count <= p.macro_count;
      req_ch.sub_time <= p.sub_time;
      req_ch.detector <= p.detector;
      req_ch.micro_channel <= p.micro_channel;
      req_ch.has_micro <= p.has_micro;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_records(p);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   function automatic photon_type random_photon(int unsigned step);
      photon_type p;
      if ($urandom_range(0, 19) == 0) cur_macro = $urandom;
      else cur_macro = cur_macro + $urandom_range(0, step);
      p.macro_count = cur_macro;
      p.sub_time = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20000);
      p.detector = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                   : 16'($signed($urandom_range(0, 12)) - 2);
      p.micro_channel = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                        : 16'($urandom_range(0, 300));
      p.has_micro = 1'($urandom_range(0, 1));
      return p;
   endfunction

   task automatic random_run(int count, int unsigned step);
      for (int i = 0; i < count; i++) send_photon(random_photon(step));
      req_ch.valid <= 0;
   endtask

   // response side: check each transaction, stall in short bursts or one long hold
   initial begin
      int         stall_left, hold_left;
      record_type e;
      stall_left = 0;
      hold_left = 0;
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready && !reset) begin
            if (pending_records.size() == 0) begin
               $error("record with nothing expected: word %h", rsp_ch.record_word);
               errors++;
            end else begin
               e = pending_records.pop_front();
               if (rsp_ch.record_word !== e.word) begin
                  $error("record_word expected %h actual %h", e.word, rsp_ch.record_word);
                  errors++;
               end
               if (rsp_ch.is_overflow !== e.ovf) begin
                  $error("is_overflow expected %b actual %b", e.ovf, rsp_ch.is_overflow);
                  errors++;
               end
               if (rsp_ch.last !== e.last) begin
                  $error("last expected %b actual %b", e.last, rsp_ch.last);
                  errors++;
               end
            end
         end
         if (hold_req && hold_left == 0) begin
            hold_left = 400;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 0;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   // watchdog: stop if nothing moves for too long
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
         if (quiet >= 4000) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      table_row_type rows[$];
      table_row_type row;
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      req_ch.valid = 0; req_ch.macro_count = 0; req_ch.sub_time = 0;
      req_ch.detector = 0; req_ch.micro_channel = 0; req_ch.has_micro = 0;
      m_sync = 12500; m_res = 3; m_tick = 1; m_nch = 4096; m_rev = 0;
      m_map = 0; m_entries = 0;
      m_wraps = 0; m_prev_macro = 0; m_ovf_total = 0; m_seen = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // macro, sub, detector, micro channel, has_micro, typed, word
      rows = '{
         '{'{32'h0, 32'h0, 16'sd0, 16'd0, 1'b0}, 1'b1, 32'h0000_0000},
         '{'{32'h0, 32'h0, -16'sd1, 16'd5, 1'b1}, 1'b1, 32'h0005_F000},
         '{'{32'h0, 32'h0, 16'sd0, 16'hFFFF, 1'b1}, 1'b1, 32'h0FFF_0000},
         '{'{32'h0, 32'h0, 16'sh7FFF, 16'd0, 1'b1}, 1'b1, 32'h0000_F000},
         '{'{32'h0, 32'h0, -16'sh8000, 16'd0, 1'b0}, 1'b0, 32'h0},
         '{'{32'h7FFF_FFFF, 32'h0, 16'sd1, 16'd0, 1'b0}, 1'b0, 32'h0},
         '{'{32'h0000_0010, 32'h0, 16'sd2, 16'd0, 1'b0}, 1'b0, 32'h0},
         '{'{32'hFFFF_FFFF, 32'h0, 16'sd3, 16'd7, 1'b1}, 1'b0, 32'h0},
         '{'{32'h0, 32'h0, 16'sd7, 16'd0, 1'b0}, 1'b0, 32'h0},
         '{'{32'h0, 32'hFFFF_FFFF, 16'sd8, 16'd0, 1'b0}, 1'b0, 32'h0},
         '{'{32'h1000, 32'd12499, 16'sd63, 16'd0, 1'b0}, 1'b0, 32'h0},
         '{'{32'h1000, 32'd12500, 16'sd64, 16'd4095, 1'b1}, 1'b0, 32'h0},
         '{'{32'h1001, 32'd1, 16'sd0, 16'd4096, 1'b1}, 1'b0, 32'h0},
         '{'{32'hAAAA_AAAA, 32'h5555_5555, 16'sh5555, 16'hAAAA, 1'b1}, 1'b0, 32'h0},
         '{'{32'h5555_5555, 32'hAAAA_AAAA, -16'sh5556, 16'h5555, 1'b0}, 1'b0, 32'h0}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_photon(row.p);
         if (row.typed && pending_records[$].word !== row.word) begin
            $error("record_word expected %h actual %h", row.word, pending_records[$].word);
            errors++;
         end
      end
      cur_macro = 32'h8000_0000;
      random_run(150, 40000);

      apply_setting(12500, 3, 1, 4096, 1, $urandom, 8);
      random_run(180, 20000);

      // tiny period and coarse ticks drive the overflow count into its clamp
      apply_setting(1, 1, 65535, 65535, 0, $urandom, 3);
      random_run(180, 5000);

      apply_setting(32'hFFFF_FFFF, 32'h00FF_FFFF, 1, 1, 1, $urandom, 0);
      random_run(180, 32'h1000_0000);

      // hold the result side off so the input backs up
      apply_setting(1000, 7, 3, 200, 0, $urandom, 5);
      hold_req = 1;
      random_run(90, 3000);
      drain();
      random_run(90, 3000);

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 2) calm = 1;
         apply_setting($urandom_range(1, 50000), $urandom_range(1, 100),
                       $urandom_range(1, 16), $urandom_range(1, 65535),
                       $urandom_range(0, 1), $urandom, $urandom_range(0, 8));
         random_run(180, 30000);
      end

      while (pending_records.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/tpre_pkg.sv
hw/rtl/tpre_if.sv
hw/rtl/tpre_csr.sv
hw/rtl/tpre_ctrl.sv
hw/rtl/tpre_dp.sv
hw/rtl/tcspc_photon_record_encoder_core.sv
bench/tb.sv
